>>> rtl/core/hdsd_pkg.sv
`default_nettype none
package hdsd_pkg;

	localparam int NODE_COUNT   = 512;
	localparam int NODE_AW      = $clog2(NODE_COUNT);
	localparam int USED_W       = $clog2(NODE_COUNT + 1);
	localparam int MAX_CODE_LEN = 16;
	localparam int CODE_W       = 16;
	localparam int CODE_IDX_W   = $clog2(CODE_W);
	localparam int LEN_W        = 5;
	localparam int RAW_BITS     = 12;
	localparam int VALUE_W      = 13;
	localparam int SAMPLE_W     = 14;
	localparam int PREV_W       = 12;
	localparam int POS_W        = 6;
	localparam int START_W      = 5;
	localparam int DATA_W       = 32;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_FULL      = 2'd1;
	localparam status_t ST_NOBRANCH  = 2'd2;
	localparam status_t ST_EXHAUSTED = 2'd3;

	typedef struct packed {
		logic                      has1;
		logic                      has0;
		logic [NODE_AW-1:0]        child1;
		logic [NODE_AW-1:0]        child0;
		logic signed [VALUE_W-1:0] value;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [POS_W-1:0]    pos;
		logic                       raw;
		status_t                    status;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_EVAL = 4'b0100,
		S_NEW  = 4'b1000
	} state_t;

endpackage
`default_nettype wire

>>> rtl/core/hdsd_ram.sv
`default_nettype none
module hdsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/hdsd_leaf.sv
`default_nettype none
module hdsd_leaf (
	input  wire logic signed [hdsd_pkg::VALUE_W-1:0] sym,
	input  wire logic signed [hdsd_pkg::VALUE_W-1:0] escape,
	input  wire logic signed [hdsd_pkg::POS_W-1:0]   pos,
	input  wire logic [hdsd_pkg::DATA_W-1:0]         data,
	input  wire logic [hdsd_pkg::PREV_W-1:0]         prev,
	input  wire logic [hdsd_pkg::START_W-1:0]        start_pos,
	output      hdsd_pkg::result_t                   res
);

	localparam int LOW_W = hdsd_pkg::POS_W + 1;

	logic signed [LOW_W-1:0]          low;
	logic [hdsd_pkg::DATA_W-1:0]      shifted;
	logic signed [hdsd_pkg::SAMPLE_W-1:0] delta_sum;

	always_comb begin
		low       = LOW_W'(pos) - LOW_W'(hdsd_pkg::RAW_BITS - 1);
		shifted   = data >> low[hdsd_pkg::START_W-1:0];
		delta_sum = hdsd_pkg::SAMPLE_W'($signed({1'b0, prev}))
			+ hdsd_pkg::SAMPLE_W'(sym);
		res = '0;
		if (sym == escape) begin
			if (low < 0) begin
				// not enough bits left for the raw sample
				res.pos    = hdsd_pkg::POS_W'(start_pos);
				res.status = hdsd_pkg::ST_EXHAUSTED;
			end else begin
				res.sample = hdsd_pkg::SAMPLE_W'(shifted[hdsd_pkg::RAW_BITS-1:0]);
				res.pos    = pos - hdsd_pkg::POS_W'(hdsd_pkg::RAW_BITS);
				res.raw    = 1'b1;
				res.status = hdsd_pkg::ST_OK;
			end
		end else begin
			res.sample = delta_sum;
			res.pos    = pos;
			res.status = hdsd_pkg::ST_OK;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/huffman_delta_sample_decoder.sv
// a decode makes one node table read per tree level (one synchronous read port)
// an insert follows each existing node with one read, and for each node allocated
// writes the parent link, clears the new node and then reads it
// throughput: one transaction at a time, busy is high until the result strobe;
// a new start is taken in the cycle the strobe is up; the receiver cannot stall
// reset: no clearing pass, the root reads as empty until first written
`default_nettype none
module huffman_delta_sample_decoder (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output      logic                                  busy,
	input  wire logic                                  kind,
	input  wire logic [hdsd_pkg::CODE_W-1:0]           code_bits,
	input  wire logic [hdsd_pkg::LEN_W-1:0]            code_length,
	input  wire logic signed [hdsd_pkg::VALUE_W-1:0]   leaf_value,
	input  wire logic [hdsd_pkg::DATA_W-1:0]           data_word,
	input  wire logic [hdsd_pkg::START_W-1:0]          start_position,
	input  wire logic [hdsd_pkg::PREV_W-1:0]           prior_sample,
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic signed [hdsd_pkg::VALUE_W-1:0]   escape_code,
	output      logic                                  result_valid,
	output      logic signed [hdsd_pkg::SAMPLE_W-1:0]  sample_value,
	output      logic signed [hdsd_pkg::POS_W-1:0]     next_position,
	output      logic                                  was_raw,
	output      hdsd_pkg::status_t                     status
);

	hdsd_pkg::state_t                    state_q, state_d;
	logic                                kind_q;
	logic [hdsd_pkg::CODE_W-1:0]         code_q;
	logic [hdsd_pkg::LEN_W-1:0]          cnt_q, cnt_d;
	logic signed [hdsd_pkg::VALUE_W-1:0] leaf_q;
	logic [hdsd_pkg::DATA_W-1:0]         data_q;
	logic [hdsd_pkg::START_W-1:0]        start_q;
	logic [hdsd_pkg::PREV_W-1:0]         prev_q;
	logic signed [hdsd_pkg::POS_W-1:0]   pos_q, pos_d;
	logic [hdsd_pkg::NODE_AW-1:0]        node_q, node_d;
	logic [hdsd_pkg::USED_W-1:0]         used_q, used_d;
	logic                                root_init_q;
	logic signed [hdsd_pkg::VALUE_W-1:0] esc_q;

	logic                                rd_en, we;
	logic [hdsd_pkg::NODE_AW-1:0]        rd_addr, waddr;
	logic [hdsd_pkg::NODE_W-1:0]         rd_data, wdata;

	hdsd_pkg::node_t                     entry, upd, leaf_upd;
	logic [hdsd_pkg::CODE_IDX_W-1:0]     bit_idx;
	logic                                b, has_b;
	logic [hdsd_pkg::NODE_AW-1:0]        child_b, new_addr;
	logic                                fin;
	hdsd_pkg::result_t                   fin_res, leaf_res;
	logic                                accept;
	logic [hdsd_pkg::LEN_W-1:0]          len_clamped;

	hdsd_ram #(
		.WIDTH(hdsd_pkg::NODE_W),
		.DEPTH(hdsd_pkg::NODE_COUNT)
	) u_node_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	hdsd_leaf u_leaf (
		.sym      (entry.value),
		.escape   (esc_q),
		.pos      (pos_q),
		.data     (data_q),
		.prev     (prev_q),
		.start_pos(start_q),
		.res      (leaf_res)
	);

	assign busy      = (state_q != hdsd_pkg::S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign new_addr  = used_q[hdsd_pkg::NODE_AW-1:0];
	assign len_clamped = (code_length > hdsd_pkg::LEN_W'(hdsd_pkg::MAX_CODE_LEN))
		? hdsd_pkg::LEN_W'(hdsd_pkg::MAX_CODE_LEN) : code_length;

	always_comb begin
		// root is cleared at reset without touching the memory
		entry   = (node_q == '0 && !root_init_q) ? '0 : hdsd_pkg::node_t'(rd_data);
		bit_idx = hdsd_pkg::CODE_IDX_W'(cnt_q - hdsd_pkg::LEN_W'(1));
		b       = kind_q ? data_q[pos_q[hdsd_pkg::START_W-1:0]] : code_q[bit_idx];
		has_b   = b ? entry.has1 : entry.has0;
		child_b = b ? entry.child1 : entry.child0;
		upd     = entry;
		if (b) begin
			upd.has1   = 1'b1;
			upd.child1 = new_addr;
		end else begin
			upd.has0   = 1'b1;
			upd.child0 = new_addr;
		end
		leaf_upd       = entry;
		leaf_upd.value = leaf_q;
	end

	always_comb begin
		state_d = state_q;
		node_d  = node_q;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		used_d  = used_q;
		rd_en   = 1'b0;
		rd_addr = node_q;
		we      = 1'b0;
		waddr   = node_q;
		wdata   = entry;
		fin     = 1'b0;
		fin_res = '0;
		case (state_q)
			hdsd_pkg::S_IDLE: begin
				if (accept) begin
					rd_en   = 1'b1;
					rd_addr = '0;
					node_d  = '0;
					cnt_d   = len_clamped;
					pos_d   = hdsd_pkg::POS_W'(start_position);
					state_d = hdsd_pkg::S_EVAL;
				end
			end
			hdsd_pkg::S_RD: begin
				rd_en   = 1'b1;
				state_d = hdsd_pkg::S_EVAL;
			end
			hdsd_pkg::S_EVAL: begin
				if (!kind_q) begin
					if (cnt_q == '0) begin
						we        = 1'b1;
						wdata     = leaf_upd;
						fin       = 1'b1;
						state_d   = hdsd_pkg::S_IDLE;
					end else if (has_b) begin
						node_d  = child_b;
						cnt_d   = cnt_q - hdsd_pkg::LEN_W'(1);
						rd_en   = 1'b1;
						rd_addr = child_b;
					end else if (used_q == hdsd_pkg::USED_W'(hdsd_pkg::NODE_COUNT)) begin
						fin            = 1'b1;
						fin_res.status = hdsd_pkg::ST_FULL;
						state_d        = hdsd_pkg::S_IDLE;
					end else begin
						// link the parent now, clear the new node next cycle
						we      = 1'b1;
						wdata   = upd;
						state_d = hdsd_pkg::S_NEW;
					end
				end else begin
					if (!(entry.has0 || entry.has1)) begin
						fin     = 1'b1;
						fin_res = leaf_res;
						state_d = hdsd_pkg::S_IDLE;
					end else if (pos_q < 0) begin
						fin            = 1'b1;
						fin_res.pos    = hdsd_pkg::POS_W'(start_q);
						fin_res.status = hdsd_pkg::ST_EXHAUSTED;
						state_d        = hdsd_pkg::S_IDLE;
					end else if (!has_b) begin
						fin            = 1'b1;
						fin_res.pos    = hdsd_pkg::POS_W'(start_q);
						fin_res.status = hdsd_pkg::ST_NOBRANCH;
						state_d        = hdsd_pkg::S_IDLE;
					end else begin
						node_d  = child_b;
						pos_d   = pos_q - hdsd_pkg::POS_W'(1);
						rd_en   = 1'b1;
						rd_addr = child_b;
					end
				end
			end
			hdsd_pkg::S_NEW: begin
				we      = 1'b1;
				waddr   = new_addr;
				wdata   = '0;
				node_d  = new_addr;
				used_d  = used_q + hdsd_pkg::USED_W'(1);
				cnt_d   = cnt_q - hdsd_pkg::LEN_W'(1);
				state_d = hdsd_pkg::S_RD;
			end
			default: begin
				state_d = hdsd_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hdsd_pkg::S_IDLE;
			used_q       <= hdsd_pkg::USED_W'(1);
			root_init_q  <= 1'b0;
			esc_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			used_q       <= used_d;
			result_valid <= fin;
			if (we && waddr == '0) begin
				root_init_q <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				esc_q <= escape_code;
			end
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
		cnt_q  <= cnt_d;
		pos_q  <= pos_d;
		if (accept) begin
			kind_q  <= kind;
			code_q  <= code_bits;
			leaf_q  <= leaf_value;
			data_q  <= data_word;
			start_q <= start_position;
			prev_q  <= prior_sample;
		end
		if (fin) begin
			sample_value  <= fin_res.sample;
			next_position <= fin_res.pos;
			was_raw       <= fin_res.raw;
			status        <= fin_res.status;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		used_q >= hdsd_pkg::USED_W'(1) && used_q <= hdsd_pkg::USED_W'(hdsd_pkg::NODE_COUNT))
		else $error("node count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hdsd_pkg::S_NEW |-> $past(state_q) == hdsd_pkg::S_EVAL && !kind_q)
		else $error("node allocation outside an insert");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == hdsd_pkg::ST_FULL |-> next_position == '0 && !was_raw)
		else $error("table full reported on a decode");

endmodule
`default_nettype wire
